### hw/rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
package tlbpt_pkg;

  // fixed widths of the stream fields
  localparam int ADDR_W   = 16;
  localparam int FIELD_W  = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_TLB_HIT   = 2'd0,
    STAT_PT_HIT    = 2'd1,
    STAT_NEW_FRAME = 2'd2,
    STAT_NO_FRAME  = 2'd3
  } status_t;

  // back end condition seen by the input handshake
  typedef struct packed {
    logic idle;
    logic clearing;
  } back_stat_t;

endpackage

### hw/rtl/tlbpt_ram.sv
`timescale 1ns / 1ps
module tlbpt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tlbpt_queue.sv
`timescale 1ns / 1ps
module tlbpt_queue #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/tlbpt_front.sv
`timescale 1ns / 1ps
module tlbpt_front #(
  parameter int TLB_ENTRIES = 16,
  parameter int OFFSET_BITS = 8,
  parameter int FRAME_COUNT = 256,
  parameter int PAGE_COUNT  = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_load,
  input  logic [tlbpt_pkg::ADDR_W-1:0]          in_addr,
  output logic                                  empty,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output logic [$clog2(FRAME_COUNT)+$clog2(PAGE_COUNT)+OFFSET_BITS:0] q_data,
  input  logic                                  tlb_we,
  input  logic [$clog2(PAGE_COUNT)-1:0]         tlb_wr_page,
  input  logic [$clog2(FRAME_COUNT)-1:0]        tlb_wr_frame
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int RAW_W   = tlbpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int RP      = (RAW_W > PAGE_W) ? RAW_W : PAGE_W;
  // reciprocal of the page count, exact quotient for every raw page number
  localparam int SH      = RAW_W + PAGE_W;
  localparam int PROD_W  = RAW_W + SH;
  localparam int RECIP   = ((2 ** SH) + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam int PTR_W   = $clog2(TLB_ENTRIES);
  localparam logic [RP-1:0] PAGE_RP = RP'(PAGE_COUNT);

  logic                   v0_r, v1_r, ld1, mv1;
  logic [RAW_W-1:0]       raw_r, quo_r, quo_nxt;
  logic [OFFSET_BITS-1:0] off0_r, off1_r;
  logic [PAGE_W-1:0]      page_r, page_nxt;
  logic [PROD_W-1:0]      prod;
  logic [RP-1:0]          rem;

  logic [PAGE_W-1:0]  tag_r [TLB_ENTRIES];
  logic [FRAME_W-1:0] frm_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_vld_r;
  logic [PTR_W-1:0]   fifo_ptr_r, fifo_ptr_nxt;
  logic [TLB_ENTRIES-1:0] match;
  logic               hit;
  logic [FRAME_W-1:0] hit_frame;

  // stage 0: quotient of the raw page number by the page count
  assign prod    = PROD_W'(in_addr[tlbpt_pkg::ADDR_W-1:OFFSET_BITS]) * PROD_W'(RECIP);
  assign quo_nxt = prod[SH +: RAW_W];

  // stage 1: remainder gives the wrapped page number
  assign rem      = RP'(raw_r) - RP'(quo_r) * PAGE_RP;
  assign page_nxt = rem[PAGE_W-1:0];

  assign ld1   = v0_r & (!v1_r | q_ready);
  assign mv1   = v1_r & q_ready;
  assign empty = !v0_r & !v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_load ? 1'b1 : (ld1 ? 1'b0 : v0_r);
      v1_r <= ld1 ? 1'b1 : (mv1 ? 1'b0 : v1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      raw_r  <= in_addr[tlbpt_pkg::ADDR_W-1:OFFSET_BITS];
      off0_r <= in_addr[OFFSET_BITS-1:0];
      quo_r  <= quo_nxt;
    end
    if (ld1) begin
      page_r <= page_nxt;
      off1_r <= off0_r;
    end
  end

  // associative lookup, lowest matching slot wins
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_vld_r[i] & (tag_r[i] == page_r);
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit       = 1'b1;
        hit_frame = frm_r[i];
      end
    end
  end

  assign q_valid = v1_r;
  assign q_data  = {hit, hit_frame, page_r, off1_r};

  // fifo replacement
  assign fifo_ptr_nxt = (fifo_ptr_r == PTR_W'(TLB_ENTRIES - 1)) ? '0 : fifo_ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_vld_r  <= '0;
      fifo_ptr_r <= '0;
    end else if (tlb_we) begin
      tlb_vld_r[fifo_ptr_r] <= 1'b1;
      fifo_ptr_r            <= fifo_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tlb_we) begin
      tag_r[fifo_ptr_r] <= tlb_wr_page;
      frm_r[fifo_ptr_r] <= tlb_wr_frame;
    end
  end

`ifndef SYNTHESIS
  a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> $onehot0(match))
    else $error("page found in more than one tlb slot");
`endif

endmodule

### hw/rtl/tlbpt_back.sv
`timescale 1ns / 1ps
module tlbpt_back #(
  parameter int OFFSET_BITS = 8,
  parameter int FRAME_COUNT = 256,
  parameter int PAGE_COUNT  = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [$clog2(FRAME_COUNT)+$clog2(PAGE_COUNT)+OFFSET_BITS:0] q_data,
  output logic                                  tlb_we,
  output logic [$clog2(PAGE_COUNT)-1:0]         tlb_wr_page,
  output logic [$clog2(FRAME_COUNT)-1:0]        tlb_wr_frame,
  output tlbpt_pkg::back_stat_t                 stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tlbpt_pkg::FIELD_W-1:0]         out_page,
  output logic [tlbpt_pkg::FIELD_W-1:0]         out_offset,
  output logic [tlbpt_pkg::FIELD_W-1:0]         out_frame,
  output logic [tlbpt_pkg::STATUS_W-1:0]        out_status
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FC_W    = $clog2(FRAME_COUNT + 1);
  localparam int FW      = tlbpt_pkg::FIELD_W;
  localparam int PW8     = (PAGE_W > FW) ? PAGE_W : FW;
  localparam int OW8     = (OFFSET_BITS > FW) ? OFFSET_BITS : FW;
  localparam int RW8     = (FRAME_W > FW) ? FRAME_W : FW;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_W-1:0]     frame;
    logic [PAGE_W-1:0]      page;
    logic [OFFSET_BITS-1:0] offset;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR   = 3'b001,
    ST_IDLE    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  entry_t              head, cur_r;
  logic [PAGE_W-1:0]   clr_cnt_r;
  logic [FC_W-1:0]     next_free_r;
  logic                pop, commit, out_free, free_ok;
  logic                map_hit, ins, alloc;
  logic [FRAME_W:0]    ram_rdata, ram_wdata;
  logic [FRAME_W-1:0]  map_frame, res_frame;
  logic [PAGE_W-1:0]   ram_waddr;
  logic                ram_we;
  tlbpt_pkg::status_t  res_status;
  logic                out_valid_r;
  logic [FW-1:0]       out_page_r, out_offset_r, out_frame_r;
  logic [tlbpt_pkg::STATUS_W-1:0] out_status_r;
  logic [PW8-1:0]      page_ext;
  logic [OW8-1:0]      off_ext;
  logic [RW8-1:0]      frame_ext;

  assign head     = q_data;
  assign pop      = (state_r == ST_IDLE) & q_valid;
  assign q_ready  = (state_r == ST_IDLE);
  assign out_free = !out_valid_r | out_ready;
  assign commit   = (state_r == ST_RESOLVE) & out_free;

  assign map_hit   = ram_rdata[FRAME_W];
  assign map_frame = ram_rdata[FRAME_W-1:0];
  assign free_ok   = (next_free_r != FC_W'(FRAME_COUNT));

  // page table: valid bit over frame number
  tlbpt_ram #(
    .WIDTH(FRAME_W + 1),
    .DEPTH(PAGE_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (pop),
    .raddr(head.page),
    .rdata(ram_rdata)
  );

  always_comb begin
    res_frame  = '0;
    res_status = tlbpt_pkg::STAT_NO_FRAME;
    ins        = 1'b0;
    alloc      = 1'b0;
    if (cur_r.hit) begin
      res_frame  = cur_r.frame;
      res_status = tlbpt_pkg::STAT_TLB_HIT;
    end else if (map_hit) begin
      res_frame  = map_frame;
      res_status = tlbpt_pkg::STAT_PT_HIT;
      ins        = 1'b1;
    end else if (free_ok) begin
      // frames are never released, so the lowest free one is the fill count
      res_frame  = next_free_r[FRAME_W-1:0];
      res_status = tlbpt_pkg::STAT_NEW_FRAME;
      ins        = 1'b1;
      alloc      = 1'b1;
    end
  end

  assign tlb_we       = commit & ins;
  assign tlb_wr_page  = cur_r.page;
  assign tlb_wr_frame = res_frame;

  assign ram_we    = (state_r == ST_CLEAR) | (commit & alloc);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : cur_r.page;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {1'b1, res_frame};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == PAGE_W'(PAGE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + PAGE_W'(1);
      end
      if (commit && alloc) begin
        next_free_r <= next_free_r + FC_W'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  assign page_ext  = PW8'(cur_r.page);
  assign off_ext   = OW8'(cur_r.offset);
  assign frame_ext = RW8'(res_frame);

  always_ff @(posedge clk) begin
    if (commit) begin
      out_page_r   <= page_ext[FW-1:0];
      out_offset_r <= off_ext[FW-1:0];
      out_frame_r  <= frame_ext[FW-1:0];
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_page   = out_page_r;
  assign out_offset = out_offset_r;
  assign out_frame  = out_frame_r;
  assign out_status = out_status_r;

  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.clearing = (state_r == ST_CLEAR);

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_valid)
    else $error("work queued during page table clearing");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !(next_free_r > FC_W'(FRAME_COUNT)))
    else $error("frame fill count past frame count");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE))
    else $error("back end did not return to idle after a result");

  a_alloc_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && alloc) |-> (!cur_r.hit && !map_hit))
    else $error("frame allocated for a mapped page");
`endif

endmodule

### hw/rtl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// one address in flight at a time; the front accepts only when the
//   lookup pipe, the queue and the back end are empty, since each miss updates the tlb
// reset: synchronous active-low; afterwards the page table memory is cleared
//   entry by entry, with in_tready low, before the first transaction
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = 16,
  parameter int OFFSET_BITS = 8,
  parameter int FRAME_COUNT = 256,
  parameter int PAGE_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] virtual address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] page_index, [15:8] page_offset, [23:16] frame_index
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int ENTRY_W = 1 + FRAME_W + PAGE_W + OFFSET_BITS;
  localparam int QDEPTH  = 2;

  // front to queue, queue to back
  logic               f_valid, f_ready, b_valid, b_ready;
  logic [ENTRY_W-1:0] f_data, b_data;
  logic               front_empty, in_load;

  // tlb refill from the back end
  logic               tlb_we;
  logic [PAGE_W-1:0]  tlb_wr_page;
  logic [FRAME_W-1:0] tlb_wr_frame;

  tlbpt_pkg::back_stat_t stat;

  logic [tlbpt_pkg::FIELD_W-1:0]  res_page, res_offset, res_frame;
  logic [tlbpt_pkg::STATUS_W-1:0] res_status;

  // one address in flight at a time; a result waiting at the output does not block
  assign in_tready = front_empty & !b_valid & stat.idle & !stat.clearing;
  assign in_load   = in_tvalid & in_tready;

  // front: page split, modulo wrap and associative tlb lookup
  tlbpt_front #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .OFFSET_BITS(OFFSET_BITS),
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_load     (in_load),
    .in_addr     (in_tdata),
    .empty       (front_empty),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_data      (f_data),
    .tlb_we      (tlb_we),
    .tlb_wr_page (tlb_wr_page),
    .tlb_wr_frame(tlb_wr_frame)
  );

  // classified lookups waiting for the back end
  tlbpt_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_data),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_data (b_data)
  );

  // back: page table read, demand allocation, tlb refill, output register
  tlbpt_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .q_data      (b_data),
    .tlb_we      (tlb_we),
    .tlb_wr_page (tlb_wr_page),
    .tlb_wr_frame(tlb_wr_frame),
    .stat        (stat),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_page    (res_page),
    .out_offset  (res_offset),
    .out_frame   (res_frame),
    .out_status  (res_status)
  );

  // pack the result transaction
  assign out_tdata = {res_frame, res_offset, res_page};
  assign out_tuser = res_status;

endmodule

### tb/sv/tlb_xlate_checker.sv
`timescale 1ns / 1ps
module tlb_xlate_checker
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 16,
  parameter int OFFSET_BITS = 8,
  parameter int FRAME_COUNT = 256,
  parameter int PAGE_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [FIELD_W-1:0] page;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] frame;
    status_t            status;
  } xlate_t;

  // shadow copy of the translator state
  int unsigned tlb_tag     [TLB_ENTRIES];
  int unsigned tlb_frame   [TLB_ENTRIES];
  bit          tlb_live    [TLB_ENTRIES];
  int unsigned fifo_ptr;
  int unsigned page_frame  [PAGE_COUNT];
  bit          page_mapped [PAGE_COUNT];
  bit          frame_taken [FRAME_COUNT];

  xlate_t expected_xlates[$];

  function automatic void tlb_fill(input int unsigned pg, input int unsigned frm);
    tlb_tag[fifo_ptr]   = pg;
    tlb_frame[fifo_ptr] = frm;
    tlb_live[fifo_ptr]  = 1'b1;
    fifo_ptr = (fifo_ptr + 1) % TLB_ENTRIES;
  endfunction

  function automatic xlate_t translate_addr(input logic [15:0] addr);
    int unsigned pg;
    int unsigned off;
    int unsigned frm;
    status_t     st;
    bit          done;
    xlate_t      r;
    pg   = (addr >> OFFSET_BITS) % PAGE_COUNT;
    off  = addr & ((1 << OFFSET_BITS) - 1);
    frm  = 0;
    st   = STAT_NO_FRAME;
    done = 1'b0;
    // lowest matching slot wins
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!done && tlb_live[i] && tlb_tag[i] == pg) begin
        frm  = tlb_frame[i];
        st   = STAT_TLB_HIT;
        done = 1'b1;
      end
    end
    if (!done) begin
      if (page_mapped[pg]) begin
        frm = page_frame[pg];
        st  = STAT_PT_HIT;
        tlb_fill(pg, frm);
      end else begin
        // lowest free frame; nothing changes when none is left
        for (int f = 0; f < FRAME_COUNT; f++) begin
          if (!done && !frame_taken[f]) begin
            frame_taken[f]  = 1'b1;
            page_frame[pg]  = f;
            page_mapped[pg] = 1'b1;
            frm  = f;
            st   = STAT_NEW_FRAME;
            done = 1'b1;
            tlb_fill(pg, f);
          end
        end
      end
    end
    r.page   = FIELD_W'(pg);
    r.offset = FIELD_W'(off);
    r.frame  = FIELD_W'(frm);
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    xlate_t want;
    xlate_t got;
    if (!rst_n) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_tag[i]   = 0;
        tlb_frame[i] = 0;
        tlb_live[i]  = 1'b0;
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
        page_frame[p]  = 0;
        page_mapped[p] = 1'b0;
      end
      for (int f = 0; f < FRAME_COUNT; f++) frame_taken[f] = 1'b0;
      fifo_ptr = 0;
      expected_xlates.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) expected_xlates.push_back(translate_addr(in_tdata));
      if (out_tvalid && out_tready) begin
        got.page   = out_tdata[7:0];
        got.offset = out_tdata[15:8];
        got.frame  = out_tdata[23:16];
        got.status = status_t'(out_tuser);
        if (expected_xlates.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result page %0d offset %0d frame %0d status %0d",
                     $time, got.page, got.offset, got.frame, got.status);
          fail_count++;
        end else begin
          want = expected_xlates.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp page %0d offset %0d frame %0d status %0d, got page %0d offset %0d frame %0d status %0d",
                       $time, want.page, want.offset, want.frame, want.status,
                       got.page, got.offset, got.frame, got.status);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_xlates.size();
  end

endmodule

### tb/sv/tb_tlb_page_table_translator.sv
`timescale 1ns / 1ps
module tb_tlb_page_table_translator;

  localparam int RANDOM_ADDRS = 1030;
  localparam int HOLD_CYCLES  = 150;   // receiver hold-off, long enough to back up the input
  localparam int HOLD_AT      = 300;   // transactions sent before the hold-off starts
  localparam int CALM_FROM    = 600;   // window with no idling on either side
  localparam int CALM_TO      = 800;
  localparam int STALL_LIMIT  = 5000;  // covers the page table clear and the hold-off
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  int fail_count;
  int pending_count;
  int n_sent;
  int stall_cycles;
  bit hold_done;

  // page pools that shape the random addresses
  logic [7:0] hot_pages  [8];
  logic [7:0] warm_pages [40];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  tlb_page_table_translator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tlb_xlate_checker chk_xlate (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic bit in_calm_window();
    return n_sent >= CALM_FROM && n_sent < CALM_TO;
  endfunction

  // offer one address and hold it until the input transaction completes;
  // tready is looked at mid-cycle, where it already holds its value for the next edge
  task automatic send_addr(input logic [15:0] addr);
    while (!in_calm_window() && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    n_sent++;
  endtask

  // mostly a hot set for tlb hits, a warm set larger than the tlb for
  // page table hits, and some fully random addresses for new frames
  function automatic logic [15:0] pick_addr();
    int unsigned sel;
    logic [7:0]  offs;
    sel  = $urandom_range(0, 99);
    offs = 8'($urandom);
    if (sel < 45) return {hot_pages[$urandom_range(0, 7)], offs};
    if (sel < 75) return {warm_pages[$urandom_range(0, 39)], offs};
    return 16'($urandom);
  endfunction

  // stimulus and verdict
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    n_sent = 0;
    foreach (hot_pages[i]) hot_pages[i] = 8'($urandom);
    foreach (warm_pages[i]) warm_pages[i] = 8'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-zero and all-one addresses, same-page tlb hits,
    // then enough new pages to push page 0 out of the tlb so its
    // next lookup goes to the page table
    send_addr(16'h0000);
    send_addr(16'h00FF);
    send_addr(16'hFFFF);
    send_addr(16'hFF00);
    send_addr(16'h5AA5);
    send_addr(16'hA55A);
    for (int p = 1; p <= 16; p++) send_addr({8'(p), 8'(p)});
    send_addr(16'h0080);

    for (int n = 0; n < RANDOM_ADDRS; n++) send_addr(pick_addr());
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random back-pressure, one long hold-off, a calm window
  initial begin
    out_tready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (in_calm_window()) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
